@@ rtl/pfct_pkg.sv @@
// ----------------------------------------------------------------------------
// pfct_pkg
// Shared types and fixed constants of the pressure floor centroid tracker.
// ----------------------------------------------------------------------------
package pfct_pkg;

	// configuration register
	localparam int                 THR_W     = 16;
	localparam logic signed [15:0] THR_RESET = -16'sd150;

	// result coordinates
	localparam int POS_W   = 10;
	localparam int POS_MAX = 1023;

	// near offset of a half-tile center, as a fraction of the tile pitch
	localparam int NEAR_NUM = 3;
	localparam int NEAR_DEN = 10;

	// frame-total queue between accumulator and divider
	localparam int FQ_DEPTH = 2;
	localparam int FQ_PW    = $clog2(FQ_DEPTH);
	localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

	// divider sequencer
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_FIN
	} pfct_bk_state_t;

endpackage

@@ rtl/pfct_front.sv @@
// ----------------------------------------------------------------------------
// pfct_front
// Sample intake: threshold test, half-tile center, weight times center,
// per-frame accumulation. Pushes frame totals into the queue on the last beat.
// ----------------------------------------------------------------------------
module pfct_front #(
	parameter int GRID_COLS   = 8,
	parameter int GRID_ROWS   = 8,
	parameter int CELL_PITCH  = 100,
	parameter int SAMPLE_BITS = 16,
	parameter int EW          = 97
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic signed [15:0]            cfg_wr_data,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last,
	input  logic [pfct_pkg::FQ_CW-1:0]    q_count,
	output logic                          push,
	output logic [EW-1:0]                 push_data
);
	import pfct_pkg::*;

	localparam int CELLS = 2 * GRID_COLS * GRID_ROWS;
	localparam int CX    = $clog2(GRID_COLS * CELL_PITCH);
	localparam int CY    = $clog2(GRID_ROWS * CELL_PITCH);
	localparam int CW    = (CX > CY) ? CX : CY;
	localparam int WW    = SAMPLE_BITS + $clog2(CELLS) + 8;
	localparam int MW    = WW + CW;
	localparam int PW    = SAMPLE_BITS + CW;
	localparam int NEAR  = (CELL_PITCH * NEAR_NUM) / NEAR_DEN;
	localparam int FAR   = CELL_PITCH - NEAR;
	localparam int CLW   = $clog2(GRID_COLS);
	localparam int RLW   = $clog2(GRID_ROWS);
	localparam int CMPW  = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
	localparam int IFW   = $clog2(FQ_DEPTH + 3);

	logic signed [15:0]       thr_q;
	logic                     odd_q;
	logic [CLW-1:0]           col_q;
	logic [RLW-1:0]           row_q;
	logic [CW-1:0]            xb_q;
	logic [CW-1:0]            yb_q;

	logic                     v_s1, hit_s1, last_s1;
	logic [SAMPLE_BITS-1:0]   w_s1;
	logic [CW-1:0]            cx_s1, cy_s1;

	logic                     v_s2, hit_s2, last_s2;
	logic [SAMPLE_BITS-1:0]   w_s2;
	logic [PW-1:0]            px_s2, py_s2;

	logic [WW-1:0]            wsum_q;
	logic [MW-1:0]            mx_q, my_q;
	logic                     any_q;

	logic                     acc;
	logic signed [CMPW-1:0]   s_ext, t_ext;
	logic                     hit;
	logic [SAMPLE_BITS-1:0]   mag, w;
	logic [CW-1:0]            ox, oy;
	logic [WW-1:0]            nws;
	logic [MW-1:0]            nmx, nmy;
	logic [IFW-1:0]           inflight;

	// frames whose totals may still need a queue slot
	assign inflight = IFW'(q_count) + IFW'(v_s1 && last_s1) + IFW'(v_s2 && last_s2);
	assign sample_stall = (inflight >= IFW'(FQ_DEPTH));
	assign acc = sample_valid && !sample_stall;

	assign s_ext = CMPW'(sample);
	assign t_ext = CMPW'(thr_q);
	assign hit   = (s_ext < t_ext);
	assign mag   = SAMPLE_BITS'(~sample) + SAMPLE_BITS'(1);
	assign w     = (hit && sample[SAMPLE_BITS-1]) ? mag : '0;

	always_comb begin
		ox = odd_q ? CW'(FAR) : CW'(NEAR);
		if (col_q[0] == row_q[0]) begin
			oy = odd_q ? CW'(NEAR) : CW'(FAR);
		end else begin
			oy = ox;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// cell position walk; wraps after a full floor, restarts on frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odd_q <= 1'b0;
			col_q <= '0;
			row_q <= '0;
			xb_q  <= '0;
			yb_q  <= '0;
		end else if (acc) begin
			if (last) begin
				odd_q <= 1'b0;
				col_q <= '0;
				row_q <= '0;
				xb_q  <= '0;
				yb_q  <= '0;
			end else if (!odd_q) begin
				odd_q <= 1'b1;
			end else begin
				odd_q <= 1'b0;
				if (col_q == CLW'(GRID_COLS - 1)) begin
					col_q <= '0;
					xb_q  <= '0;
					if (row_q == RLW'(GRID_ROWS - 1)) begin
						row_q <= '0;
						yb_q  <= '0;
					end else begin
						row_q <= row_q + RLW'(1);
						yb_q  <= yb_q + CW'(CELL_PITCH);
					end
				end else begin
					col_q <= col_q + CLW'(1);
					xb_q  <= xb_q + CW'(CELL_PITCH);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		hit_s1  <= hit;
		last_s1 <= last;
		w_s1    <= w;
		cx_s1   <= xb_q + ox;
		cy_s1   <= yb_q + oy;
		hit_s2  <= hit_s1;
		last_s2 <= last_s1;
		w_s2    <= w_s1;
		px_s2   <= PW'(w_s1) * PW'(cx_s1);
		py_s2   <= PW'(w_s1) * PW'(cy_s1);
	end

	assign nws = wsum_q + WW'(w_s2);
	assign nmx = mx_q + MW'(px_s2);
	assign nmy = my_q + MW'(py_s2);

	assign push      = v_s2 && last_s2;
	assign push_data = {any_q | hit_s2, nws, nmx, nmy};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsum_q <= '0;
			mx_q   <= '0;
			my_q   <= '0;
			any_q  <= 1'b0;
		end else if (v_s2) begin
			if (last_s2) begin
				wsum_q <= '0;
				mx_q   <= '0;
				my_q   <= '0;
				any_q  <= 1'b0;
			end else begin
				wsum_q <= nws;
				mx_q   <= nmx;
				my_q   <= nmy;
				any_q  <= any_q | hit_s2;
			end
		end
	end

endmodule

@@ rtl/pfct_queue.sv @@
// ----------------------------------------------------------------------------
// pfct_queue
// Short register queue of frame totals between accumulator and divider.
// ----------------------------------------------------------------------------
module pfct_queue #(
	parameter int EW = 97
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [EW-1:0]              push_data,
	input  logic                       pop,
	output logic [EW-1:0]              pop_data,
	output logic [pfct_pkg::FQ_CW-1:0] count
);
	import pfct_pkg::*;

	logic [EW-1:0]    mem_q [FQ_DEPTH];
	logic [FQ_PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FQ_CW-1:0] cnt_q;

	function automatic logic [FQ_PW-1:0] ptr_inc(input logic [FQ_PW-1:0] p);
		ptr_inc = (p == FQ_PW'(FQ_DEPTH - 1)) ? '0 : p + FQ_PW'(1);
	endfunction

	assign pop_data = mem_q[rd_ptr_q];
	assign count    = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + FQ_CW'(1);
				2'b01:   cnt_q <= cnt_q - FQ_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/pfct_back.sv @@
// ----------------------------------------------------------------------------
// pfct_back
// Frame-end divider: restoring division of both moments by the weight sum,
// one quotient bit per cycle, then saturation and the result register.
// ----------------------------------------------------------------------------
module pfct_back #(
	parameter int GRID_COLS   = 8,
	parameter int GRID_ROWS   = 8,
	parameter int CELL_PITCH  = 100,
	parameter int SAMPLE_BITS = 16,
	parameter int EW          = 97
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [EW-1:0]              pop_data,
	input  logic [pfct_pkg::FQ_CW-1:0] q_count,
	output logic                       pop,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic                       present,
	output logic [pfct_pkg::POS_W-1:0] pos_x,
	output logic [pfct_pkg::POS_W-1:0] pos_y
);
	import pfct_pkg::*;

	localparam int CELLS = 2 * GRID_COLS * GRID_ROWS;
	localparam int CX    = $clog2(GRID_COLS * CELL_PITCH);
	localparam int CY    = $clog2(GRID_ROWS * CELL_PITCH);
	localparam int CW    = (CX > CY) ? CX : CY;
	localparam int WW    = SAMPLE_BITS + $clog2(CELLS) + 8;
	localparam int MW    = WW + CW;
	localparam int SW    = $clog2(CW);

	pfct_bk_state_t state_q, state_d;

	logic            any_q, zero_q;
	logic [MW-1:0]   dsh_q, remx_q, remy_q;
	logic [CW-1:0]   qx_q, qy_q;
	logic [SW-1:0]   step_q;
	logic            out_valid_q, present_q;
	logic [POS_W-1:0] posx_q, posy_q;

	logic            f_any;
	logic [WW-1:0]   f_ws;
	logic [MW-1:0]   f_mx, f_my;
	logic            gex, gey;
	logic            ld, stp, out_ld, slot_free;
	logic [POS_W-1:0] satx, saty;

	assign f_any = pop_data[EW-1];
	assign f_ws  = pop_data[2*MW +: WW];
	assign f_mx  = pop_data[MW +: MW];
	assign f_my  = pop_data[0 +: MW];

	assign gex = (remx_q >= dsh_q);
	assign gey = (remy_q >= dsh_q);

	assign slot_free = !out_valid_q || !result_stall;

	// quotient never exceeds the floor span; clamp only to the port range
	assign satx = ({1'b0, qx_q} > (CW + 1)'(POS_MAX)) ? POS_W'(POS_MAX) : POS_W'(qx_q);
	assign saty = ({1'b0, qy_q} > (CW + 1)'(POS_MAX)) ? POS_W'(POS_MAX) : POS_W'(qy_q);

	always_comb begin
		state_d = state_q;
		ld      = 1'b0;
		stp     = 1'b0;
		out_ld  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_count != '0) begin
					ld      = 1'b1;
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				stp = 1'b1;
				if (step_q == '0) begin
					state_d = BK_FIN;
				end
			end
			BK_FIN: begin
				if (slot_free) begin
					out_ld  = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign pop = ld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			any_q  <= f_any;
			zero_q <= (f_ws == '0);
			dsh_q  <= MW'(f_ws) << (CW - 1);
			remx_q <= f_mx;
			remy_q <= f_my;
			qx_q   <= '0;
			qy_q   <= '0;
			step_q <= SW'(CW - 1);
		end else if (stp) begin
			remx_q <= gex ? remx_q - dsh_q : remx_q;
			remy_q <= gey ? remy_q - dsh_q : remy_q;
			qx_q   <= {qx_q[CW-2:0], gex};
			qy_q   <= {qy_q[CW-2:0], gey};
			dsh_q  <= dsh_q >> 1;
			step_q <= step_q - SW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			present_q <= any_q;
			posx_q    <= (any_q && !zero_q) ? satx : '0;
			posy_q    <= (any_q && !zero_q) ? saty : '0;
		end
	end

	assign result_valid = out_valid_q;
	assign present      = present_q;
	assign pos_x        = posx_q;
	assign pos_y        = posy_q;

endmodule

@@ rtl/pressure_floor_centroid_tracker_top.sv @@
// Throughput: one sample beat per cycle unless intake stalls; the bit-serial divider
//   works on one frame at a time and takes the next only after the last result is
//   loaded, with CW = clog2(max(GRID_COLS, GRID_ROWS) * CELL_PITCH) quotient bits.
//   Intake stalls while two frame totals are queued or still on their way to the queue.
// Reset (arst_n low, asynchronous): accumulators, cell walk, queue and result
//   valid clear; the threshold returns to -150.
// ----------------------------------------------------------------------------
// pressure_floor_centroid_tracker_top
// Weighted footstep centroid over a floor of triangular pressure cells.
// ----------------------------------------------------------------------------
module pressure_floor_centroid_tracker_top #(
	parameter int GRID_COLS   = 8,
	parameter int GRID_ROWS   = 8,
	parameter int CELL_PITCH  = 100,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// threshold register write
	input  logic                          cfg_wr_en,
	input  logic signed [15:0]            cfg_wr_data,
	// sample channel
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last,
	// result channel
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          present,
	output logic [pfct_pkg::POS_W-1:0]    pos_x,
	output logic [pfct_pkg::POS_W-1:0]    pos_y
);
	import pfct_pkg::*;

	// accumulator widths: weight sum keeps 8 bits of headroom beyond one
	// full floor of full-scale hits; moments add the coordinate width
	localparam int CELLS = 2 * GRID_COLS * GRID_ROWS;
	localparam int CX    = $clog2(GRID_COLS * CELL_PITCH);
	localparam int CY    = $clog2(GRID_ROWS * CELL_PITCH);
	localparam int CW    = (CX > CY) ? CX : CY;
	localparam int WW    = SAMPLE_BITS + $clog2(CELLS) + 8;
	localparam int MW    = WW + CW;
	// queue entry: hit flag, weight sum, x moment, y moment
	localparam int EW    = 1 + WW + 2 * MW;

	logic             push, pop;
	logic [EW-1:0]    push_data, pop_data;
	logic [FQ_CW-1:0] q_count;

	// front: threshold, half-tile center, weight product, frame accumulation
	pfct_front #(
		.GRID_COLS  (GRID_COLS),
		.GRID_ROWS  (GRID_ROWS),
		.CELL_PITCH (CELL_PITCH),
		.SAMPLE_BITS(SAMPLE_BITS),
		.EW         (EW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.last        (last),
		.q_count     (q_count),
		.push        (push),
		.push_data   (push_data)
	);

	// frame totals wait here while the divider works on an earlier frame
	pfct_queue #(
		.EW(EW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.count    (q_count)
	);

	// back: divider and result register; a stalled result holds the divider, and a full queue then stalls intake
	pfct_back #(
		.GRID_COLS  (GRID_COLS),
		.GRID_ROWS  (GRID_ROWS),
		.CELL_PITCH (CELL_PITCH),
		.SAMPLE_BITS(SAMPLE_BITS),
		.EW         (EW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_data    (pop_data),
		.q_count     (q_count),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.present     (present),
		.pos_x       (pos_x),
		.pos_y       (pos_y)
	);

endmodule
